/* rtl/gpit_pkg.sv */
// Shared types, constants and helpers for the GF(2) irreducibility tester.
// No dependencies.
package gpit_pkg;

   localparam int PolyW = 64;
   localparam int DegW  = 6;

   typedef logic [PolyW-1:0] poly_type;
   typedef logic [DegW-1:0]  deg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQR_GO,
      ST_SQR_WAIT,
      ST_GCD_GO,
      ST_GCD_WAIT,
      ST_DONE
   } gpit_state_type;

   typedef struct packed {
      logic done;
      logic coprime;
   } gcd_stat_type;

   // v * x mod p, deg v < d = deg p
   function automatic poly_type times_x(poly_type v, poly_type p, deg_type d);
      poly_type t;
      t = {v[PolyW-2:0], 1'b0};
      if (t[d]) begin
         t = t ^ p;
      end
      return t;
   endfunction

endpackage

/* rtl/gpit_sqr_mod.sv */
// Bit-serial modular squaring over GF(2)[x]: one multiplier bit per cycle.
// Depends on gpit_pkg.
module gpit_sqr_mod (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  gpit_pkg::poly_type v,
   input  gpit_pkg::poly_type p,
   input  gpit_pkg::deg_type  d,
   output logic             done,
   output gpit_pkg::poly_type result
);
   import gpit_pkg::*;

   poly_type acc_ff, acc_in;
   poly_type v_ff, v_in;
   poly_type vsh_ff, vsh_in;
   deg_type  cnt_ff, cnt_in;
   logic     busy_ff, busy_in;
   logic     done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      v_in    = v_ff;
      vsh_in  = vsh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         v_in    = v;
         vsh_in  = v;
         cnt_in  = deg_type'(PolyW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Horner step, top multiplier bit first
         acc_in = times_x(acc_ff, p, d) ^ (vsh_ff[PolyW-1] ? v_ff : '0);
         vsh_in = {vsh_ff[PolyW-2:0], 1'b0};
         cnt_in = cnt_ff - deg_type'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      v_ff   <= v_in;
      vsh_ff <= vsh_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

/* rtl/gpit_gcd.sv */
// Binary GCD over GF(2)[x] with degree tracking counters, one step per cycle.
// Reports whether the two operands are coprime. Depends on gpit_pkg.
module gpit_gcd (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  gpit_pkg::poly_type a,
   input  gpit_pkg::poly_type b,
   input  gpit_pkg::deg_type  d,
   output gpit_pkg::gcd_stat_type stat
);
   import gpit_pkg::*;

   poly_type a_ff, a_in;
   poly_type b_ff, b_in;
   deg_type  da_ff, da_in;
   deg_type  db_ff, db_in;
   logic     busy_ff, busy_in;
   gcd_stat_type stat_ff, stat_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      da_in   = da_ff;
      db_in   = db_ff;
      busy_in = busy_ff;
      stat_in = '{done: 1'b0, coprime: stat_ff.coprime};
      if (start) begin
         a_in    = a;
         b_in    = b;
         da_in   = d;
         db_in   = d;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // da/db are upper bounds on the degrees, tightened one step at a time
         priority if (a_ff == '0) begin
            busy_in = 1'b0;
            stat_in = '{done: 1'b1, coprime: (b_ff == poly_type'(1))};
         end else if (b_ff == '0) begin
            busy_in = 1'b0;
            stat_in = '{done: 1'b1, coprime: (a_ff == poly_type'(1))};
         end else if (!a_ff[0] && !b_ff[0]) begin
            busy_in = 1'b0;
            stat_in = '{done: 1'b1, coprime: 1'b0};
         end else if (!a_ff[0]) begin
            a_in  = {1'b0, a_ff[PolyW-1:1]};
            da_in = da_ff - deg_type'(1);
         end else if (!b_ff[0]) begin
            b_in  = {1'b0, b_ff[PolyW-1:1]};
            db_in = db_ff - deg_type'(1);
         end else if (!a_ff[da_ff]) begin
            da_in = da_ff - deg_type'(1);
         end else if (!b_ff[db_ff]) begin
            db_in = db_ff - deg_type'(1);
         end else if (da_ff >= db_ff) begin
            a_in = a_ff ^ b_ff;
         end else begin
            b_in = b_ff ^ a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      b_ff  <= b_in;
      da_ff <= da_in;
      db_ff <= db_in;
      if (reset) begin
         busy_ff <= 1'b0;
         stat_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         stat_ff <= stat_in;
      end
   end

   assign stat = stat_ff;

endmodule

/* rtl/gf2_poly_irreducibility_test.sv */
// Ben-Or irreducibility test over GF(2)[x], one request at a time.
// Operation: degree 0 or 1 goes straight to the result; otherwise degree/2
// rounds, each a bit-serial squaring plus a binary GCD.
// A new request is taken only after the last result is loaded; it may wait in the output register.
// Reset: synchronous; degree returns to 31, control idles, no result pending.
module gf2_poly_irreducibility_test #(
   parameter int MAX_DEGREE = 63
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  gpit_pkg::poly_type req_random_bits,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output gpit_pkg::poly_type rsp_tested_poly,
   output logic               rsp_is_irreducible,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  gpit_pkg::deg_type  csr_degree
);
   import gpit_pkg::*;

   gpit_state_type state_ff, state_in;
   deg_type  degree_ff;
   deg_type  d_sat;
   poly_type mask;
   poly_type poly_ff, poly_in;
   poly_type xmod_ff, xmod_in;
   poly_type res_ff, res_in;
   deg_type  d_ff, d_in;
   deg_type  round_ff, round_in;
   logic     ok_ff, ok_in;
   logic     rsp_valid_ff;
   poly_type rsp_poly_ff;
   logic     rsp_irr_ff;
   logic     sqr_start, sqr_done, gcd_start, rsp_load;
   poly_type sqr_result;
   gcd_stat_type gcd_stat;

   assign d_sat = (degree_ff > deg_type'(MAX_DEGREE)) ? deg_type'(MAX_DEGREE) : degree_ff;
   assign mask  = (d_sat == '1) ? '1 : ((poly_type'(1) << ({1'b0, d_sat} + 7'd1))
                                        - poly_type'(1));
   assign poly_in = (req_random_bits & mask) | (poly_type'(1) << d_sat);

   gpit_sqr_mod u_sqr (
      .clock  (clock),
      .reset  (reset),
      .start  (sqr_start),
      .v      (res_ff),
      .p      (poly_ff),
      .d      (d_ff),
      .done   (sqr_done),
      .result (sqr_result)
   );

   gpit_gcd u_gcd (
      .clock (clock),
      .reset (reset),
      .start (gcd_start),
      .a     (res_ff ^ xmod_ff),
      .b     (poly_ff),
      .d     (d_ff),
      .stat  (gcd_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (d_sat[DegW-1:1] == '0) ? ST_DONE : ST_SQR_GO;
            end
         end
         ST_SQR_GO:   state_in = ST_SQR_WAIT;
         ST_SQR_WAIT: if (sqr_done) state_in = ST_GCD_GO;
         ST_GCD_GO:   state_in = ST_GCD_WAIT;
         ST_GCD_WAIT: begin
            if (gcd_stat.done) begin
               if (!gcd_stat.coprime || round_ff == {1'b0, d_ff[DegW-1:1]}) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SQR_GO;
               end
            end
         end
         ST_DONE: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      sqr_start = (state_ff == ST_SQR_GO);
      gcd_start = (state_ff == ST_GCD_GO);
      rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   // datapath registers
   always_comb begin
      xmod_in  = xmod_ff;
      res_in   = res_ff;
      d_in     = d_ff;
      round_in = round_ff;
      ok_in    = ok_ff;
      unique case (state_ff)
         ST_IDLE: begin
            d_in     = d_sat;
            xmod_in  = times_x(poly_type'(1), poly_in, d_sat);
            res_in   = xmod_in;
            round_in = deg_type'(1);
            // degree 0 is a unit; degree 1 needs no round
            ok_in    = (d_sat != '0);
         end
         ST_SQR_WAIT: if (sqr_done) res_in = sqr_result;
         ST_GCD_WAIT: begin
            if (gcd_stat.done) begin
               ok_in    = gcd_stat.coprime;
               round_in = round_ff + deg_type'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      xmod_ff  <= xmod_in;
      res_ff   <= res_in;
      d_ff     <= d_in;
      round_ff <= round_in;
      ok_ff    <= ok_in;
      if (state_ff == ST_IDLE) begin
         poly_ff <= poly_in;
      end
      if (rsp_load) begin
         rsp_poly_ff <= poly_ff;
         rsp_irr_ff  <= ok_ff;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         degree_ff    <= deg_type'(31);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            degree_ff <= csr_degree;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tested_poly    = rsp_poly_ff;
   assign rsp_is_irreducible = rsp_irr_ff;

endmodule
